// ===== sv/i2c_master_transaction_sequencer_unit_assert.svh =====
// Assertion macros for the I2C master transaction sequencer.
// Included by the top level; no other dependencies.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication under reset.
`define I2C_MTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c_mts: same-cycle check failed");

// Next-cycle implication under reset.
`define I2C_MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c_mts: next-cycle check failed");

`endif

// ===== sv/i2c_mts_pkg.sv =====
// Shared types and codes for the I2C master transaction sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package i2c_mts_pkg;

    localparam int TX_POS_W   = 5;
    localparam int POS_SPAN   = 2 ** TX_POS_W;

    // request types
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_EVENT = 2'd2;

    // bus controller status codes
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RESTART      = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK   = 8'h20;
    localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_TX_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
    localparam logic [7:0] ST_SLA_R_NACK   = 8'h48;
    localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

    localparam logic [7:0] RX_SINGLE = 8'h01;

    // ack control codes
    localparam logic [1:0] ACK_KEEP = 2'd0;
    localparam logic [1:0] ACK_NEXT = 2'd1;
    localparam logic [1:0] NACK_NEXT = 2'd2;

    // transfer phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_PENDING   = 3'd1;
    localparam logic [2:0] PH_DONE      = 3'd2;
    localparam logic [2:0] PH_ADDR_NACK = 3'd3;
    localparam logic [2:0] PH_DATA_NACK = 3'd4;
    localparam logic [2:0] PH_ARB_LOST  = 3'd5;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] byte_index;
        logic [7:0] byte_value;
        logic [4:0] write_count;
        logic [7:0] read_count;
        logic [7:0] status_code;
        logic [7:0] rx_data;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       request_start;
        logic       clear_start;
        logic       request_stop;
        logic [1:0] ack_control;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [2:0] phase;
    } result_t;

    typedef struct packed {
        logic [TX_POS_W-1:0] tx_pos;
        logic [7:0]          rx_pos;
        logic [TX_POS_W-1:0] tx_total;
        logic [7:0]          rx_total;
        logic [2:0]          phase;
    } state_t;

endpackage

// ===== sv/i2c_mts_txbuf.sv =====
// Transmit byte buffer: one write port, one registered read port with write bypass.
// Depends on i2c_mts_pkg for the position width.
`timescale 1ns / 1ps

module i2c_mts_txbuf #(
    parameter int TX_DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [i2c_mts_pkg::TX_POS_W-1:0] wr_pos,
    input  logic [7:0]                       wr_data,
    input  logic                             rd_en,
    input  logic [i2c_mts_pkg::TX_POS_W-1:0] rd_pos,
    output logic [7:0]                       rd_data
);

    localparam int ADDR_W = $clog2(TX_DEPTH);

    logic [7:0]        mem [TX_DEPTH];
    logic [ADDR_W-1:0] pos_to_addr [i2c_mts_pkg::POS_SPAN];
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data_reg;

    // position modulo depth, folded at elaboration
    for (genvar g = 0; g < i2c_mts_pkg::POS_SPAN; g++)
    begin : g_mod
        assign pos_to_addr[g] = ADDR_W'(g % TX_DEPTH);
    end

    assign wr_addr = pos_to_addr[wr_pos];
    assign rd_addr = pos_to_addr[rd_pos];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a load leaving the decision stage in the same cycle wins over the array
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/i2c_mts_decide.sv =====
// Decision logic: one item plus current state gives one result and the next state.
// Depends on i2c_mts_pkg for item, result and state types and the status codes.
`timescale 1ns / 1ps

module i2c_mts_decide (
    input  i2c_mts_pkg::item_t   item,
    input  i2c_mts_pkg::state_t  st,
    input  logic [7:0]           buf_byte,
    output i2c_mts_pkg::result_t res,
    output i2c_mts_pkg::state_t  st_next,
    output logic                 buf_wr
);

    logic [7:0] rx_inc;
    logic [7:0] rx_last;

    assign rx_inc  = st.rx_pos + 8'd1;
    assign rx_last = st.rx_total - 8'd1;

    always_comb
    begin
        res     = '0;
        st_next = st;
        buf_wr  = 1'b0;
        case (item.req_type)
            i2c_mts_pkg::REQ_LOAD:
            begin
                buf_wr = 1'b1;
            end
            i2c_mts_pkg::REQ_START:
            begin
                st_next.tx_total = item.write_count;
                st_next.rx_total = item.read_count;
                st_next.tx_pos   = '0;
                st_next.rx_pos   = '0;
                st_next.phase    = i2c_mts_pkg::PH_IDLE;
                res.request_start = 1'b1;
            end
            i2c_mts_pkg::REQ_EVENT:
            begin
                case (item.status_code)
                    i2c_mts_pkg::ST_START:
                    begin
                        // buffer byte was read at position zero
                        res.tx_valid    = 1'b1;
                        res.tx_byte     = buf_byte;
                        st_next.tx_pos  = i2c_mts_pkg::TX_POS_W'(1);
                        res.clear_start = 1'b1;
                        st_next.phase   = i2c_mts_pkg::PH_PENDING;
                    end
                    i2c_mts_pkg::ST_RESTART:
                    begin
                        st_next.rx_pos  = '0;
                        res.tx_valid    = 1'b1;
                        res.tx_byte     = buf_byte;
                        st_next.tx_pos  = st.tx_pos + 1'b1;
                        res.clear_start = 1'b1;
                    end
                    i2c_mts_pkg::ST_SLA_W_ACK:
                    begin
                        res.tx_valid   = 1'b1;
                        res.tx_byte    = buf_byte;
                        st_next.tx_pos = st.tx_pos + 1'b1;
                    end
                    i2c_mts_pkg::ST_SLA_W_NACK, i2c_mts_pkg::ST_SLA_R_NACK:
                    begin
                        res.request_stop = 1'b1;
                        st_next.phase    = i2c_mts_pkg::PH_ADDR_NACK;
                    end
                    i2c_mts_pkg::ST_DATA_TX_ACK:
                    begin
                        if (st.tx_pos < st.tx_total)
                        begin
                            res.tx_valid   = 1'b1;
                            res.tx_byte    = buf_byte;
                            st_next.tx_pos = st.tx_pos + 1'b1;
                        end
                        else if (st.rx_total != 8'd0)
                        begin
                            res.request_start = 1'b1;
                        end
                        else
                        begin
                            res.request_stop = 1'b1;
                            st_next.phase    = i2c_mts_pkg::PH_DONE;
                        end
                    end
                    i2c_mts_pkg::ST_DATA_TX_NACK:
                    begin
                        res.request_stop = 1'b1;
                        st_next.phase    = i2c_mts_pkg::PH_DATA_NACK;
                    end
                    i2c_mts_pkg::ST_ARB_LOST:
                    begin
                        st_next.phase = i2c_mts_pkg::PH_ARB_LOST;
                    end
                    i2c_mts_pkg::ST_SLA_R_ACK:
                    begin
                        res.ack_control = (st.rx_total == i2c_mts_pkg::RX_SINGLE) ?
                            i2c_mts_pkg::NACK_NEXT : i2c_mts_pkg::ACK_NEXT;
                    end
                    i2c_mts_pkg::ST_DATA_RX_ACK:
                    begin
                        res.rx_valid    = 1'b1;
                        res.rx_byte     = item.rx_data;
                        st_next.rx_pos  = rx_inc;
                        // rx_total of zero wraps to 255 here
                        res.ack_control = (rx_inc < rx_last) ?
                            i2c_mts_pkg::ACK_NEXT : i2c_mts_pkg::NACK_NEXT;
                    end
                    i2c_mts_pkg::ST_DATA_RX_NACK:
                    begin
                        res.rx_valid     = 1'b1;
                        res.rx_byte      = item.rx_data;
                        st_next.rx_pos   = rx_inc;
                        res.request_stop = 1'b1;
                        st_next.phase    = i2c_mts_pkg::PH_DONE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        res.phase = st_next.phase;
    end

endmodule

// ===== sv/i2c_master_transaction_sequencer_unit.sv =====
// I2C master transaction sequencer, top level: handshakes, state and result registers.
// Depends on i2c_mts_pkg, i2c_mts_txbuf, i2c_mts_decide and the assertion header.
//
// Use: one valid/ready input channel carries load, start and bus status items;
// one valid/ready output channel returns exactly one result item per input item,
// in order. Load items fill the transmit buffer (address byte at index 0), a
// start item arms a transfer and requests START, and each status event returns
// the next byte, start/stop/clear requests, ACK/NACK control, a received byte
// and the transfer phase.
// Timing: the input register loads when an item is accepted, and the result
// register loads when that item leaves the decision stage.
// Throughput: one item per clock while out_ready is high, set by the single
// decision stage; the buffer read for an item is taken as it enters.
// Reset: positions, totals and phase clear to zero/idle, both stages empty;
// buffer contents are undefined until loaded.
// Stall: the result register holds while out_ready is low; the input register
// then holds one more item and in_ready falls until the result is taken.
`timescale 1ns / 1ps
`include "i2c_master_transaction_sequencer_unit_assert.svh"

module i2c_master_transaction_sequencer_unit #(
    parameter int TX_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [3:0] byte_index,
    input  logic [7:0] byte_value,
    input  logic [4:0] write_count,
    input  logic [7:0] read_count,
    input  logic [7:0] status_code,
    input  logic [7:0] rx_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       request_start,
    output logic       clear_start,
    output logic       request_stop,
    output logic [1:0] ack_control,
    output logic       rx_valid,
    output logic [7:0] rx_byte,
    output logic [2:0] phase
);

    i2c_mts_pkg::item_t   item_reg;
    logic                 s1_valid_reg;
    i2c_mts_pkg::state_t  st_reg;
    i2c_mts_pkg::state_t  st_next;
    i2c_mts_pkg::result_t res_next;
    i2c_mts_pkg::result_t res_reg;
    logic                 out_valid_reg;

    logic                                in_fire;
    logic                                s1_fire;
    logic                                buf_wr;
    logic [7:0]                          buf_byte;
    logic [i2c_mts_pkg::TX_POS_W-1:0]    pos_base;
    logic [i2c_mts_pkg::TX_POS_W-1:0]    rd_pos;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    // read address for the entering item follows the item leaving the stage
    assign pos_base = s1_fire ? st_next.tx_pos : st_reg.tx_pos;
    assign rd_pos   = ((req_type == i2c_mts_pkg::REQ_EVENT) &&
                       (status_code == i2c_mts_pkg::ST_START)) ? '0 : pos_base;

    i2c_mts_txbuf #(
        .TX_DEPTH (TX_DEPTH)
    ) u_txbuf (
        .clk     (clk),
        .wr_en   (s1_fire && buf_wr),
        .wr_pos  ({1'b0, item_reg.byte_index}),
        .wr_data (item_reg.byte_value),
        .rd_en   (in_fire),
        .rd_pos  (rd_pos),
        .rd_data (buf_byte)
    );

    i2c_mts_decide u_decide (
        .item     (item_reg),
        .st       (st_reg),
        .buf_byte (buf_byte),
        .res      (res_next),
        .st_next  (st_next),
        .buf_wr   (buf_wr)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.req_type    <= req_type;
            item_reg.byte_index  <= byte_index;
            item_reg.byte_value  <= byte_value;
            item_reg.write_count <= write_count;
            item_reg.read_count  <= read_count;
            item_reg.status_code <= status_code;
            item_reg.rx_data     <= rx_data;
        end
        if (s1_fire)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_valid      = res_reg.tx_valid;
    assign tx_byte       = res_reg.tx_byte;
    assign request_start = res_reg.request_start;
    assign clear_start   = res_reg.clear_start;
    assign request_stop  = res_reg.request_stop;
    assign ack_control   = res_reg.ack_control;
    assign rx_valid      = res_reg.rx_valid;
    assign rx_byte       = res_reg.rx_byte;
    assign phase         = res_reg.phase;

    `I2C_MTS_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, s1_fire, out_valid_reg)
    `I2C_MTS_ASSERT_IMPLY(a_empty_stage_ready, clk, rst_n, !s1_valid_reg, in_ready)
    `I2C_MTS_ASSERT_IMPLY(a_blocked_stage, clk, rst_n, s1_valid_reg && !s1_fire, !in_ready)
    `I2C_MTS_ASSERT_IMPLY(a_tx_rx_exclusive, clk, rst_n, out_valid_reg, !(tx_valid && rx_valid))
    `I2C_MTS_ASSERT_IMPLY(a_idle_tx_zero, clk, rst_n, out_valid_reg && !tx_valid, tx_byte == 8'd0)

endmodule
